// File: rtl/core/qtg_pkg.sv
// ----------------------------------------------------------------------------
// qtg_pkg: shared definitions for the queued tone generator
// Widths, register codes, controller states, command and status words, and
// the quarter-wave sine entry function used to build the sine ROM.
// ----------------------------------------------------------------------------
package qtg_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF     = 16;
    localparam int SINE_TABLE_BITS_DEF = 8;

    // Field widths
    localparam int FREQ_W   = 15;
    localparam int DUR_W    = 16;
    localparam int AMP_W    = 15;
    localparam int SPM_W    = 8;
    localparam int STEP_W   = 24;
    localparam int LEN_W    = 24;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int QCOUNT_W = 5;
    localparam int SINE_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Register reset values
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST = AMP_W'(28000);
    localparam logic [SPM_W-1:0]  SPM_RST       = SPM_W'(44);
    localparam logic [STEP_W-1:0] STEP_RST      = STEP_W'(97613);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMPLITUDE      = 2'd0,
        CFG_SAMPLES_PER_MS = 2'd1,
        CFG_PHASE_STEP     = 2'd2
    } cfg_idx_t;

    // Request codes
    typedef enum logic {
        REQ_ENQUEUE = 1'b0,
        REQ_TICK    = 1'b1
    } req_t;

    // Multiplier operand select
    typedef enum logic [1:0] {
        MUL_LEN,
        MUL_AMP,
        MUL_INC
    } mul_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ_MUL,
        ST_ENQ_WR,
        ST_SINE,
        ST_AMP,
        ST_ADV,
        ST_WAIT,
        ST_LOAD,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     cap_in;
        mul_sel_t mul_sel;
        logic     ld_len;
        logic     enq_write;
        logic     ld_sine;
        logic     ld_prod;
        logic     tick_adv;
        logic     ld_head;
        logic     ld_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic queue_empty;
        logic queue_full;
        logic pop_refill;
    } status_t;

    // Series coefficients (2k)(2k+1) for k = 1..7
    localparam logic [63:0] SINE_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Q15 quarter-wave entry: 32767 * sin(pi/2 * idx / 2^tbits), clamped
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned tbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = (PI_HALF_Q30 * 64'(idx)) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x2) >> 30;
            term = term / SINE_DIV[k-1];
            if ((k & 1) != 0)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        v = ((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[SINE_W-1:0];
    endfunction

endpackage

// File: rtl/core/qtg_ram.sv
// ----------------------------------------------------------------------------
// qtg_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module qtg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/qtg_ctrl.sv
// ----------------------------------------------------------------------------
// qtg_ctrl: sequencer for the queued tone generator
// Steps one word at a time through enqueue or sample-tick work and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module qtg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  qtg_pkg::status_t status,
    output qtg_pkg::cmd_t    cmd
);

    qtg_pkg::state_t state_reg;
    qtg_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qtg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = qtg_pkg::MUL_LEN;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            qtg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    if (!status.is_tick)
                        state_next = qtg_pkg::ST_ENQ_MUL;
                    else if (status.queue_empty)
                        state_next = qtg_pkg::ST_DONE;
                    else
                        state_next = qtg_pkg::ST_SINE;
                end
            end
            qtg_pkg::ST_ENQ_MUL:
            begin
                cmd.mul_sel = qtg_pkg::MUL_LEN;
                cmd.ld_len  = 1'b1;
                state_next  = qtg_pkg::ST_ENQ_WR;
            end
            qtg_pkg::ST_ENQ_WR:
            begin
                cmd.enq_write = 1'b1;
                state_next    = qtg_pkg::ST_DONE;
            end
            qtg_pkg::ST_SINE:
            begin
                cmd.ld_sine = 1'b1;
                state_next  = qtg_pkg::ST_AMP;
            end
            qtg_pkg::ST_AMP:
            begin
                cmd.mul_sel = qtg_pkg::MUL_AMP;
                cmd.ld_prod = 1'b1;
                state_next  = qtg_pkg::ST_ADV;
            end
            qtg_pkg::ST_ADV:
            begin
                cmd.mul_sel  = qtg_pkg::MUL_INC;
                cmd.tick_adv = 1'b1;
                state_next   = status.pop_refill ? qtg_pkg::ST_WAIT : qtg_pkg::ST_DONE;
            end
            qtg_pkg::ST_WAIT:
            begin
                // new head entry is on its way out of the RAM
                state_next = qtg_pkg::ST_LOAD;
            end
            qtg_pkg::ST_LOAD:
            begin
                cmd.ld_head = 1'b1;
                state_next  = qtg_pkg::ST_DONE;
            end
            qtg_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.ld_out     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = qtg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qtg_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != qtg_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/qtg_dp.sv
// ----------------------------------------------------------------------------
// qtg_dp: datapath of the queued tone generator
// Holds the registers, the tone FIFO, the phase accumulator, the sine ROM,
// one shared multiplier and the output word register.
// ----------------------------------------------------------------------------
module qtg_dp #(
    parameter int QUEUE_DEPTH     = qtg_pkg::QUEUE_DEPTH_DEF,
    parameter int SINE_TABLE_BITS = qtg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [qtg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qtg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              req_type,
    input  logic [qtg_pkg::FREQ_W-1:0]        frequency,
    input  logic [qtg_pkg::DUR_W-1:0]         duration_ms,
    output logic signed [qtg_pkg::SAMPLE_W-1:0] sample,
    output logic                              accepted,
    output logic [qtg_pkg::QCOUNT_W-1:0]      queue_count,
    input  qtg_pkg::cmd_t                     cmd,
    output qtg_pkg::status_t                  status
);

    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W  = qtg_pkg::FREQ_W + qtg_pkg::LEN_W;
    localparam int TBL_SIZE = (1 << SINE_TABLE_BITS) + 1;
    localparam int IDX_W    = SINE_TABLE_BITS + 1;

    // Configuration registers
    logic [qtg_pkg::AMP_W-1:0]  amp_reg;
    logic [qtg_pkg::SPM_W-1:0]  spm_reg;
    logic [qtg_pkg::STEP_W-1:0] step_reg;

    // Captured request
    logic                       tick_reg;
    logic [qtg_pkg::FREQ_W-1:0] freq_reg;
    logic [qtg_pkg::DUR_W-1:0]  dur_reg;

    // Queue control and tone state
    logic [PTR_W-1:0]            rd_ptr_reg;
    logic [PTR_W-1:0]            wr_ptr_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [qtg_pkg::LEN_W-1:0]   head_reg;
    logic [qtg_pkg::PHASE_W-1:0] phase_reg;

    // Working registers
    logic [qtg_pkg::LEN_W-1:0]  len_reg;
    logic [qtg_pkg::SINE_W-1:0] mag_reg;
    logic                       neg_reg;
    logic [qtg_pkg::SINE_W-1:0] prod_reg;
    logic [qtg_pkg::SAMPLE_W-1:0] res_sample_reg;
    logic                       res_acc_reg;

    // Output word
    logic [qtg_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                         out_acc_reg;
    logic [qtg_pkg::QCOUNT_W-1:0] out_count_reg;

    // FIFO RAM signals
    logic [ENTRY_W-1:0]         ram_rdata;
    logic [qtg_pkg::FREQ_W-1:0] head_freq;
    logic [qtg_pkg::LEN_W-1:0]  head_len;
    logic                       enq_ok;
    logic                       ram_we;

    // Shared multiplier
    logic [qtg_pkg::MUL_A_W-1:0] mul_a;
    logic [qtg_pkg::MUL_B_W-1:0] mul_b;
    logic [qtg_pkg::MUL_P_W-1:0] mul_p;

    // Sine lookup
    logic [qtg_pkg::SINE_W-1:0] sine_rom [TBL_SIZE];
    logic [IDX_W-1:0]           idx_raw;
    logic [IDX_W-1:0]           idx;

    // Pointer and count helpers
    logic [PTR_W-1:0]             rd_ptr_inc;
    logic [PTR_W-1:0]             wr_ptr_inc;
    logic                         queue_empty;
    logic                         queue_full;
    logic                         pop;
    logic [qtg_pkg::SAMPLE_W-1:0] prod_ext;

    // Build the sine ROM at elaboration
    for (genvar g = 0; g < TBL_SIZE; g++)
    begin : g_rom
        assign sine_rom[g] = qtg_pkg::sine_entry(g, SINE_TABLE_BITS);
    end

    // Tone FIFO storage: frequency over length
    qtg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata ({freq_reg, len_reg}),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign head_freq = ram_rdata[ENTRY_W-1 -: qtg_pkg::FREQ_W];
    assign head_len  = ram_rdata[qtg_pkg::LEN_W-1:0];

    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign enq_ok      = (len_reg != '0) && !queue_full;
    assign ram_we      = cmd.enq_write && enq_ok;
    assign pop         = (head_reg == qtg_pkg::LEN_W'(1));

    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;

    // Select multiplier operands
    always_comb
    begin
        unique case (cmd.mul_sel)
            qtg_pkg::MUL_LEN:
            begin
                mul_a = qtg_pkg::MUL_A_W'(dur_reg);
                mul_b = qtg_pkg::MUL_B_W'(spm_reg);
            end
            qtg_pkg::MUL_AMP:
            begin
                mul_a = qtg_pkg::MUL_A_W'(amp_reg);
                mul_b = qtg_pkg::MUL_B_W'(mag_reg);
            end
            qtg_pkg::MUL_INC:
            begin
                mul_a = step_reg;
                mul_b = qtg_pkg::MUL_B_W'(head_freq);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Quadrant mirror of the table index
    assign idx_raw = {1'b0, phase_reg[qtg_pkg::PHASE_W-3 -: SINE_TABLE_BITS]};
    assign idx     = phase_reg[qtg_pkg::PHASE_W-2] ? IDX_W'(TBL_SIZE - 1) - idx_raw : idx_raw;

    assign prod_ext = {1'b0, prod_reg};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg  <= qtg_pkg::AMPLITUDE_RST;
            spm_reg  <= qtg_pkg::SPM_RST;
            step_reg <= qtg_pkg::STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qtg_pkg::CFG_AMPLITUDE:      amp_reg  <= cfg_data[qtg_pkg::AMP_W-1:0];
                qtg_pkg::CFG_SAMPLES_PER_MS: spm_reg  <= cfg_data[qtg_pkg::SPM_W-1:0];
                qtg_pkg::CFG_PHASE_STEP:     step_reg <= cfg_data[qtg_pkg::STEP_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Queue pointers, count, head length and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            head_reg   <= '0;
            phase_reg  <= '0;
        end
        else
        begin
            if (ram_we)
            begin
                wr_ptr_reg <= wr_ptr_inc;
                count_reg  <= count_reg + 1'b1;
                if (queue_empty)
                    head_reg <= len_reg;
            end
            if (cmd.tick_adv)
            begin
                phase_reg <= phase_reg + mul_p[qtg_pkg::PHASE_W-1:0];
                head_reg  <= head_reg - 1'b1;
                if (pop)
                begin
                    rd_ptr_reg <= rd_ptr_inc;
                    count_reg  <= count_reg - 1'b1;
                end
            end
            if (cmd.ld_head)
                head_reg <= head_len;
        end
    end

    // Request capture and working values
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            tick_reg       <= req_type;
            freq_reg       <= frequency;
            dur_reg        <= duration_ms;
            res_sample_reg <= '0;
            res_acc_reg    <= 1'b0;
        end
        if (cmd.ld_len)
            len_reg <= mul_p[qtg_pkg::LEN_W-1:0];
        if (ram_we)
            res_acc_reg <= 1'b1;
        if (cmd.ld_sine)
        begin
            mag_reg <= sine_rom[idx];
            neg_reg <= phase_reg[qtg_pkg::PHASE_W-1];
        end
        if (cmd.ld_prod)
            prod_reg <= mul_p[2*qtg_pkg::SINE_W-1 -: qtg_pkg::SINE_W];
        if (cmd.tick_adv)
            res_sample_reg <= neg_reg ? ('0 - prod_ext) : prod_ext;
        if (cmd.ld_out)
        begin
            out_sample_reg <= res_sample_reg;
            out_acc_reg    <= res_acc_reg;
            out_count_reg  <= qtg_pkg::QCOUNT_W'(count_reg);
        end
    end

    // Status back to the sequencer
    assign status.is_tick     = (req_type == qtg_pkg::REQ_TICK);
    assign status.queue_empty = queue_empty;
    assign status.queue_full  = queue_full;
    assign status.pop_refill  = pop && (count_reg > CNT_W'(1)) && tick_reg;

    assign sample      = signed'(out_sample_reg);
    assign accepted    = out_acc_reg;
    assign queue_count = out_count_reg;

endmodule

// File: rtl/core/queued_tone_generator.sv
// ----------------------------------------------------------------------------
// queued_tone_generator: beeper with a tone FIFO and a DDS sine output
// Enqueue words push tones into the FIFO; tick words play the head tone one
// sample at a time, amplitude times a quarter-wave sine of the phase.
//
//   channel   | valid     | stall     | payload
//   ----------+-----------+-----------+----------------------------------
//   request   | in_valid  | in_stall  | req_type, frequency, duration_ms
//   result    | out_valid | out_stall | sample, accepted, queue_count
//   registers | cfg_we    | (none)    | cfg_index, cfg_data
//
// One word is in work at a time. An enqueue computes the tone length and
// writes the FIFO; a tick on a non-empty queue looks up the sine, scales it
// and advances the phase, and when the head tone ends with more queued reads
// the next head length from the FIFO RAM; an empty-queue tick goes straight out.
// Steps use the one shared multiplier at most once; the RAM read is registered.
// A finished word waits in the output register while the next one is taken.
// Reset is asynchronous, active low; it clears pointers, count, phase, head
// length and the registers to their defaults.
// ----------------------------------------------------------------------------
module queued_tone_generator #(
    parameter int QUEUE_DEPTH     = qtg_pkg::QUEUE_DEPTH_DEF,
    parameter int SINE_TABLE_BITS = qtg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [qtg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qtg_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic [qtg_pkg::FREQ_W-1:0]           frequency,
    input  logic [qtg_pkg::DUR_W-1:0]            duration_ms,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [qtg_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 accepted,
    output logic [qtg_pkg::QCOUNT_W-1:0]         queue_count
);

    qtg_pkg::cmd_t    cmd;
    qtg_pkg::status_t status;

    // Sequencer
    qtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    qtg_dp #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .frequency   (frequency),
        .duration_ms (duration_ms),
        .sample      (sample),
        .accepted    (accepted),
        .queue_count (queue_count),
        .cmd         (cmd),
        .status      (status)
    );

    // One word in work at a time: an accept is followed by a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while previous word still in work");

    // The queue is never both empty and full
    assert property (@(posedge clk) disable iff (!rst_n)
        !(status.queue_empty && status.queue_full))
        else $error("queue count inconsistent");

    // A stored tone reports a zero sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (sample == '0))
        else $error("enqueue result carries a nonzero sample");

    // A head reload only follows a pop with refill seen in the phase-advance step
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_head |-> $past(status.pop_refill, 2))
        else $error("head reload without a pop");

endmodule
